### design/first_fit_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator_defines
// Assertion macros used by the allocator datapath.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FFBA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator same-cycle check failed");
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator next-cycle check failed");
`else
`define FFBA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int ADDR_BITS   = 20;
  localparam int REQ_W       = 20;
  localparam int LIMIT_W     = 21;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W      = REQ_W + 1;
  localparam int CMP_W       = (ADDR_BITS + 1 > LIMIT_W + 2) ? ADDR_BITS + 1 : LIMIT_W + 2;
  localparam int HDR_BYTES   = 32;
  localparam int ALIGN_BYTES = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);
  localparam logic [CMP_W-1:0]   ADDR_MASK   = CMP_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } ffba_status_t;

  typedef struct packed {
    logic                 free;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] offset;
  } ffba_entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ffba_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic null_free;
  } ffba_stat_t;

endpackage

### design/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: load an item, scan the block table, commit the result.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ffba_pkg::ffba_stat_t stat,
  output logic                busy,
  output ffba_pkg::ffba_cmd_t  cmd
);

  import ffba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.null_free || stat.hit || stat.exhausted) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.step   = (state == S_SCAN);
  assign cmd.commit = (state == S_WRITE);

endmodule

### design/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp
// Block table, scan pipeline, append arithmetic and result registers.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_defines.svh"

module ffba_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  ffba_pkg::ffba_cmd_t              cmd,
  output ffba_pkg::ffba_stat_t             stat,
  input  logic                             command,
  input  logic [ffba_pkg::REQ_W-1:0]       request_size,
  input  logic [ffba_pkg::ADDR_BITS-1:0]   address,
  input  logic                             cfg_valid,
  input  logic [ffba_pkg::LIMIT_W-1:0]     cfg_data,
  output logic                             done,
  output logic [1:0]                       result_status,
  output logic [ffba_pkg::ADDR_BITS-1:0]   result_addr
);

  import ffba_pkg::*;

  logic [LIMIT_W-1:0]   heap_limit;
  logic [LIMIT_W-1:0]   heap_end;
  logic [CNT_W-1:0]     block_count;

  logic                 cmd_r;
  logic [SIZE_W-1:0]    need;
  logic [ADDR_BITS-1:0] addr_r;

  logic [CNT_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     chk_idx;
  logic                 chk_valid;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  ffba_entry_t          found_word;

  ffba_entry_t          rd_word;
  ffba_entry_t          wr_word;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic                 ram_re;
  logic                 more;
  logic                 match;

  logic [CMP_W-1:0]     hdr_end;
  logic [CMP_W-1:0]     new_end;
  logic                 no_space;
  logic                 append;
  ffba_status_t         res_status;
  logic [ADDR_BITS-1:0] res_addr;

  ffba_ram #(
    .WIDTH ($bits(ffba_entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_word),
    .re    (ram_re),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_word)
  );

  // scan
  assign more = (rd_idx < block_count);

  always_comb begin
    if (cmd_r == CMD_FREE) begin
      match = ({1'b0, rd_word.offset} + (ADDR_BITS+1)'(HDR_BYTES)) == {1'b0, addr_r};
    end else begin
      match = rd_word.free && (rd_word.size >= need);
    end
  end

  assign stat.hit       = chk_valid && match;
  assign stat.exhausted = !chk_valid && !more;
  assign stat.null_free = (cmd_r == CMD_FREE) && (addr_r == '0);
  assign ram_re         = cmd.step && !stat.hit && more;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.load) begin
      rd_idx    <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.step) begin
      if (stat.hit) begin
        found     <= 1'b1;
        chk_valid <= 1'b0;
      end else if (more) begin
        rd_idx    <= rd_idx + CNT_W'(1);
        chk_valid <= 1'b1;
      end else begin
        chk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= command;
      addr_r <= address;
      need   <= ({1'b0, request_size} + SIZE_W'(ALIGN_BYTES - 1)) &
                ~SIZE_W'(ALIGN_BYTES - 1);
    end
    if (cmd.step && ram_re) begin
      chk_idx <= rd_idx[IDX_W-1:0];
    end
    if (cmd.step && stat.hit) begin
      found_idx  <= chk_idx;
      found_word <= rd_word;
    end
  end

  // commit
  assign hdr_end  = CMP_W'(heap_end) + CMP_W'(HDR_BYTES);
  assign new_end  = hdr_end + CMP_W'(need);
  assign no_space = (new_end > CMP_W'(heap_limit)) || (hdr_end > ADDR_MASK);

  always_comb begin
    res_status = ST_OK;
    res_addr   = '0;
    append     = 1'b0;
    if (cmd_r == CMD_FREE) begin
      if (addr_r != '0 && !found) begin
        res_status = ST_NOTFOUND;
      end
    end else if (found) begin
      res_addr = found_word.offset + ADDR_BITS'(HDR_BYTES);
    end else if (block_count == CNT_W'(MAX_BLOCKS)) begin
      res_status = ST_FULL;
    end else if (no_space) begin
      res_status = ST_NOSPACE;
    end else begin
      append   = 1'b1;
      res_addr = ADDR_BITS'(hdr_end);
    end
  end

  always_comb begin
    if (found) begin
      wr_word      = found_word;
      wr_word.free = (cmd_r == CMD_FREE);
      ram_waddr    = found_idx;
    end else begin
      wr_word.free   = 1'b0;
      wr_word.size   = need;
      wr_word.offset = ADDR_BITS'(heap_end);
      ram_waddr      = block_count[IDX_W-1:0];
    end
  end

  assign ram_we = cmd.commit && (append || (found && !stat.null_free));

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit  <= LIMIT_RESET;
      heap_end    <= '0;
      block_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cfg_valid) begin
        heap_limit <= cfg_data;
      end
      if (cmd.commit && append) begin
        heap_end    <= LIMIT_W'(new_end);
        block_count <= block_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_status <= res_status;
      result_addr   <= res_addr;
    end
  end

  `FFBA_ASSERT_IMPL(a_fail_no_addr, clk, rst, done && result_status != ST_OK, result_addr == '0)
  `FFBA_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, block_count <= CNT_W'(MAX_BLOCKS))
  `FFBA_ASSERT_NEXT(a_commit_done, clk, rst, cmd.commit, done)
  `FFBA_ASSERT_NEXT(a_count_hold, clk, rst, !cmd.commit, $stable(block_count) && $stable(heap_end))

endmodule

### design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of back-to-back blocks with 32-byte headers.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Allocate rounds the
// size up to a multiple of 16 bytes, reuses the first free block that fits,
// else appends a block behind heap_end; free marks the block whose payload
// offset matches. The table is scanned one entry per cycle through a
// registered-read RAM, stopping at the first hit. Each result shows on status
// and payload_address for one cycle with done, in the cycle busy drops; it
// cannot be held off, so the receiver must take it then. The user must write
// heap_limit through cfg_valid/cfg_data only while idle; the block does not
// enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [ffba_pkg::REQ_W-1:0]     request_size,
  input  logic [ffba_pkg::ADDR_BITS-1:0] address,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffba_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [ffba_pkg::ADDR_BITS-1:0] payload_address
);

  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  assign cfg_ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  ffba_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .request_size  (request_size),
    .address       (address),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .done          (done),
    .result_status (status),
    .result_addr   (payload_address)
  );

endmodule

### tb/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the allocator's item, result and register channels, keeps its own
// copy of the block table and the arena end, works out the expected status
// and payload address of every accepted item and compares each result, in
// order, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ffba_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           command,
  input  logic [ffba_pkg::REQ_W-1:0]     request_size,
  input  logic [ffba_pkg::ADDR_BITS-1:0] address,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ffba_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                           done,
  input  logic [1:0]                     status,
  input  logic [ffba_pkg::ADDR_BITS-1:0] payload_address,
  input  logic                           end_of_test,
  output int                             fail_count
);

  import ffba_pkg::*;

  typedef struct packed {
    ffba_status_t         st;
    logic [ADDR_BITS-1:0] addr;
  } outcome_t;

  longint unsigned blk_offset[MAX_BLOCKS];
  longint unsigned blk_size[MAX_BLOCKS];
  bit              blk_free[MAX_BLOCKS];
  int              blk_count;
  longint unsigned heap_top;
  longint unsigned arena_limit;
  outcome_t        outcome_q[$];

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic outcome_t heap_outcome(logic cmd, logic [REQ_W-1:0] req,
                                            logic [ADDR_BITS-1:0] addr);
    outcome_t        r;
    longint unsigned need;
    longint unsigned fin;
    longint unsigned addr_max;
    bit              hit;
    r.st     = ST_OK;
    r.addr   = '0;
    hit      = 1'b0;
    addr_max = (64'd1 << ADDR_BITS) - 64'd1;
    if (cmd == CMD_ALLOC) begin
      need = (longint'(req) + ALIGN_BYTES - 1) & ~longint'(ALIGN_BYTES - 1);
      for (int i = 0; i < blk_count; i++) begin
        if (!hit && blk_free[i] && blk_size[i] >= need) begin
          hit         = 1'b1;
          blk_free[i] = 1'b0;
          r.addr      = ADDR_BITS'(blk_offset[i] + HDR_BYTES);
        end
      end
      if (!hit) begin
        fin = heap_top + HDR_BYTES + need;
        if (blk_count >= MAX_BLOCKS) begin
          r.st = ST_FULL;
        end else if (fin > arena_limit || heap_top + HDR_BYTES > addr_max) begin
          r.st = ST_NOSPACE;
        end else begin
          blk_offset[blk_count] = heap_top;
          blk_size[blk_count]   = need;
          blk_free[blk_count]   = 1'b0;
          blk_count++;
          r.addr   = ADDR_BITS'(heap_top + HDR_BYTES);
          heap_top = fin;
        end
      end
    end else if (addr != '0) begin
      for (int i = 0; i < blk_count; i++) begin
        if (!hit && blk_offset[i] + HDR_BYTES == longint'(addr)) begin
          hit         = 1'b1;
          blk_free[i] = 1'b1;
        end
      end
      if (!hit) r.st = ST_NOTFOUND;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t exp_r;
    if (rst) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        blk_offset[i] = 0;
        blk_size[i]   = 0;
        blk_free[i]   = 1'b0;
      end
      blk_count   = 0;
      heap_top    = 0;
      arena_limit = longint'(LIMIT_RESET);
      fail_count  = 0;
      outcome_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) arena_limit = longint'(cfg_data);
      if (done) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing outstanding: status %0d addr 0x%05h",
                                  status, payload_address));
        end else begin
          exp_r = outcome_q.pop_front();
          if (ffba_status_t'(status) !== exp_r.st)
            flag_mismatch($sformatf("status %0d, expected %0d", status, exp_r.st));
          if (payload_address !== exp_r.addr)
            flag_mismatch($sformatf("payload_address 0x%05h, expected 0x%05h",
                                    payload_address, exp_r.addr));
        end
      end
      if (start && !busy)
        outcome_q.push_back(heap_outcome(command, request_size, address));
      if (end_of_test && outcome_q.size() != 0) begin
        flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        outcome_q.delete();
      end
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the first-fit block allocator: a directed pass over the size
// extremes, reuse, null/unknown/double free and a lowered limit, then random
// allocate and free items in phases with different heap limits and random
// idle gaps. Checking is done by ffba_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ffba_pkg::*;

  localparam int RAND_ITEMS  = 1200;
  localparam int PHASE_LEN   = 150;
  localparam int CYCLE_LIMIT = 1000000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 command;
  logic [REQ_W-1:0]     request_size;
  logic [ADDR_BITS-1:0] address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;
  logic                 done;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] payload_address;
  logic                 end_of_test;
  int                   fail_count;

  int                   issued;
  int                   returned = 0;
  int                   cycles = 0;
  bit                   no_idle;
  logic [ADDR_BITS-1:0] live_addr[$];

  first_fit_block_allocator u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .request_size    (request_size),
    .address         (address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .done            (done),
    .status          (status),
    .payload_address (payload_address)
  );

  ffba_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .request_size    (request_size),
    .address         (address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .done            (done),
    .status          (status),
    .payload_address (payload_address),
    .end_of_test     (end_of_test),
    .fail_count      (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // results seen so far, and live payload addresses for later frees
  always @(posedge clk) begin
    if (!rst && done) begin
      returned <= returned + 1;
      if (ffba_status_t'(status) == ST_OK && payload_address != '0) begin
        live_addr.push_back(payload_address);
        if (live_addr.size() > 96) live_addr.delete(0);
      end
    end
  end

  task automatic issue_item(logic cmd, logic [REQ_W-1:0] sz, logic [ADDR_BITS-1:0] ad);
    int gap;
    start        <= 1'b1;
    command      <= cmd;
    request_size <= sz;
    address      <= ad;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (issued != returned);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] random_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return REQ_W'($urandom_range(0, 64));
    if (p < 90) return REQ_W'($urandom_range(65, 4096));
    if (p < 97) return REQ_W'($urandom_range(0, 20'hFFFFF));
    return (p < 99) ? REQ_W'(20'hFFFFF) : '0;
  endfunction

  function automatic logic [ADDR_BITS-1:0] random_free_addr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70 && live_addr.size() > 0) return live_addr[$urandom_range(0, live_addr.size() - 1)];
    if (p < 80) return '0;
    if (p < 90) return ADDR_BITS'($urandom_range(0, 8192) & ~15);
    return ADDR_BITS'($urandom_range(0, 20'hFFFFF));
  endfunction

  initial begin
    int lim_sel;
    start        <= 1'b0;
    command      <= CMD_ALLOC;
    request_size <= '0;
    address      <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    end_of_test  <= 1'b0;
    issued   = 0;
    no_idle  = 1'b0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero size, rounding edges, frees, reuse, size extremes
    issue_item(CMD_ALLOC, 20'd0, 20'hFFFFF);
    issue_item(CMD_ALLOC, 20'd1, 20'd0);
    issue_item(CMD_ALLOC, 20'd16, 20'h55555);
    issue_item(CMD_ALLOC, 20'd17, 20'hAAAAA);
    issue_item(CMD_FREE, 20'hFFFFF, 20'd0);
    issue_item(CMD_FREE, 20'd0, 20'd64);
    issue_item(CMD_FREE, 20'h55555, 20'd64);
    issue_item(CMD_FREE, 20'd0, 20'd65);
    issue_item(CMD_FREE, 20'hAAAAA, 20'hFFFFF);
    issue_item(CMD_ALLOC, 20'd10, 20'd0);
    issue_item(CMD_ALLOC, 20'd0, 20'd0);
    issue_item(CMD_FREE, 20'd0, 20'd32);
    issue_item(CMD_ALLOC, 20'd0, 20'd0);
    issue_item(CMD_ALLOC, 20'hFFFFF, 20'd0);
    issue_item(CMD_ALLOC, 20'h80000, 20'd0);
    issue_item(CMD_FREE, 20'd0, 20'd288);
    issue_item(CMD_ALLOC, 20'h7FFF1, 20'd0);
    // limit below the arena end: appends fail, frees and reuse still work
    drain_results();
    write_limit(LIMIT_W'(0));
    issue_item(CMD_ALLOC, 20'd0, 20'd0);
    issue_item(CMD_FREE, 20'd0, 20'd112);
    issue_item(CMD_ALLOC, 20'd16, 20'd0);
    issue_item(CMD_ALLOC, 20'd17, 20'd0);
    drain_results();
    write_limit(LIMIT_RESET);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n != 0 && n % PHASE_LEN == 0) begin
        drain_results();
        lim_sel = (n / PHASE_LEN) % 4;
        case (lim_sel)
          1: write_limit(LIMIT_W'($urandom_range(0, 1048576)));
          3: write_limit(LIMIT_W'($urandom_range(0, 4096)));
          default: write_limit(LIMIT_RESET);
        endcase
      end else if ($urandom_range(0, 49) == 0) begin
        drain_results();
      end
      no_idle = (n % 200) < 40;
      if ($urandom_range(0, 99) < 55)
        issue_item(CMD_ALLOC, random_size(), ADDR_BITS'($urandom_range(0, 20'hFFFFF)));
      else
        issue_item(CMD_FREE, REQ_W'($urandom_range(0, 20'hFFFFF)), random_free_addr());
    end

    drain_results();
    repeat (80) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
